>>> sv/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types and constants of the small vm execute unit: instruction kinds,
// status codes, register numbers, the decoded micro-op and the result record.
// ----------------------------------------------------------------------------
package svm_pkg;

    // instruction kinds, no-op serves every undefined code
    typedef enum logic [4:0] {
        K_EXIT, K_MOVI, K_ADD, K_MOV, K_SUB, K_MUL, K_DIV, K_INC, K_DEC,
        K_JMP, K_CMPEQ, K_CMPLT, K_JT, K_JNT, K_PUSH, K_POP, K_LOAD,
        K_STORE, K_LOADI, K_STOREI, K_LOADSC, K_STORESC, K_PENDOWN,
        K_PENUP, K_NOP
    } t_kind;

    // result status codes
    typedef enum logic [2:0] {
        S_OK, S_WR_SC, S_WR_R0, S_TC_RANGE, S_OVF_HIGH, S_OVF_LOW,
        S_DIV_ZERO, S_STACK_RANGE
    } t_status;

    // register numbering
    localparam logic [3:0] REG_R0 = 4'd0;
    localparam logic [3:0] REG_PC = 4'd8;
    localparam logic [3:0] REG_SC = 4'd9;
    localparam logic [3:0] REG_TC = 4'd11;
    localparam int         NUM_REGS = 12;

    // depth of the queue between front and back
    localparam int         FIFO_DEPTH = 2;

    // back end sequencer states
    typedef enum logic [3:0] {
        BK_CLEAR, BK_IDLE, BK_RD_BC, BK_RD_A, BK_CAP_A, BK_EXEC, BK_MEM,
        BK_DIV, BK_WB
    } t_state;

    // decoded instruction handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  reg_a;
        logic [3:0]  reg_b;
        logic [3:0]  reg_c;
        logic [31:0] imm;
        logic        stk_rd;
        logic        stk_wr;
    } t_uop;

    // one result record
    typedef struct packed {
        t_status     status;
        logic        fatal;
        logic        exit_req;
        logic        test_flag;
        logic        pen_down;
        logic        jump_taken;
        logic [31:0] jump_target;
        logic        dest_written;
        logic [31:0] dest_value;
    } t_result;

endpackage

>>> sv/svm_ram.sv
// ----------------------------------------------------------------------------
// svm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/svm_fifo.sv
// ----------------------------------------------------------------------------
// svm_fifo
// Short flop queue of decoded instructions between front and back.
// ----------------------------------------------------------------------------
module svm_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  svm_pkg::t_uop i_data,
    output logic          o_full,
    input  logic          i_pop,
    output svm_pkg::t_uop o_data,
    output logic          o_valid
);
    import svm_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_uop                r_mem [FIFO_DEPTH];
    logic [PW-1:0]       r_wp;
    logic [PW-1:0]       r_rp;
    logic [PW:0]         r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

>>> sv/svm_front.sv
// ----------------------------------------------------------------------------
// svm_front
// Input stage: takes instruction transfers, classifies the kind and hands
// the decoded instruction to the queue.
// ----------------------------------------------------------------------------
module svm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [4:0]    i_kind,
    input  logic [3:0]    i_reg_a,
    input  logic [3:0]    i_reg_b,
    input  logic [3:0]    i_reg_c,
    input  logic [31:0]   i_imm,
    input  logic          i_hold,
    input  logic          i_q_full,
    output logic          o_q_push,
    output svm_pkg::t_uop o_uop
);
    import svm_pkg::*;

    logic r_vld;
    t_uop r_uop;
    t_uop dec;
    logic accept;

    // classify the instruction
    always_comb begin
        dec       = '0;
        dec.kind  = (i_kind > 5'(K_PENUP)) ? K_NOP : t_kind'(i_kind);
        dec.reg_a = i_reg_a;
        dec.reg_b = i_reg_b;
        dec.reg_c = i_reg_c;
        dec.imm   = i_imm;
        dec.stk_rd = dec.kind inside {K_POP, K_LOAD, K_LOADI, K_LOADSC};
        dec.stk_wr = dec.kind inside {K_PUSH, K_STORE, K_STOREI, K_STORESC};
    end

    assign o_full   = i_hold || (r_vld && i_q_full);
    assign accept   = i_push && !o_full;
    assign o_q_push = r_vld && !i_q_full;
    assign o_uop    = r_uop;

    // holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= accept || (r_vld && i_q_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_uop <= dec;
    end

endmodule

>>> sv/svm_div.sv
// ----------------------------------------------------------------------------
// svm_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero; the quotient comes out 33 bits wide so that overflow can be judged.
// ----------------------------------------------------------------------------
module svm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [32:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_q;
    logic [31:0] r_d;
    logic        r_neg;
    logic [32:0] trial;
    logic [32:0] diff;

    assign trial = {r_rem[31:0], r_q[31]};
    assign diff  = trial - {1'b0, r_d};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring step on magnitudes
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            r_d   <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            r_neg <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff;
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (33'd0 - {1'b0, r_q}) : {1'b0, r_q};

endmodule

>>> sv/svm_back.sv
// ----------------------------------------------------------------------------
// svm_back
// Execute stage: reads operands, runs the instruction against register file,
// stack and flags, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module svm_back #(
    parameter int STACK_DEPTH = 256,
    parameter int TC_MAX      = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  svm_pkg::t_uop    i_uop,
    input  logic             i_uop_valid,
    output logic             o_uop_pop,
    output logic             o_clearing,
    output svm_pkg::t_result o_res,
    output logic             o_res_valid,
    input  logic             i_res_pop
);
    import svm_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int RAW = $clog2(NUM_REGS);

    t_state              r_state, n_state;
    t_uop                r_uop;
    logic [NUM_REGS-1:0] r_rf_vld;
    logic [31:0]         r_sc;
    logic [31:0]         r_va, r_vb, r_vc;
    logic [63:0]         r_prod;
    logic [31:0]         r_sd;
    logic                r_idx_ok;
    logic [AW-1:0]       r_saddr;
    logic [AW-1:0]       r_clr;
    logic                r_test, r_pen, r_exit;
    t_result             r_res;
    logic                r_res_vld;

    // ram ports
    logic [RAW-1:0] rf_ra0, rf_ra1, rf_wa;
    logic [31:0]    rf_rd0, rf_rd1, rf_wd;
    logic           rf_we;
    logic [AW-1:0]  st_ra, st_wa;
    logic [31:0]    st_rd, st_wd;
    logic           st_we;

    // divider
    logic        div_start, div_done;
    logic [32:0] div_q;

    // execute signals
    logic [31:0] idx;
    logic        idx_ok;
    logic [32:0] add_x, sub_x;
    logic        reg_req, commit, stk_req, jump, fatal;
    logic [31:0] reg_val, stk_val;
    t_status     ovf_st, ref_st, fatal_st, wb_st;
    logic        n_test, n_pen, n_exit;

    function automatic logic [31:0] rf_map(input logic [3:0] ri,
                                           input logic [NUM_REGS-1:0] vld,
                                           input logic [31:0] dout,
                                           input logic [31:0] sc);
        logic [31:0] v;
        v = '0;
        if (ri == REG_SC) v = sc;
        else if (ri < 4'(NUM_REGS) && vld[ri]) v = dout;
        return v;
    endfunction

    function automatic t_status ovf33(input logic [32:0] x);
        t_status s;
        s = S_OK;
        if (!x[32] && x[31]) s = S_OVF_HIGH;
        else if (x[32] && !x[31]) s = S_OVF_LOW;
        return s;
    endfunction

    function automatic t_status ovf64(input logic [63:0] x);
        t_status s;
        s = S_OK;
        if (!x[63] && (|x[62:31])) s = S_OVF_HIGH;
        else if (x[63] && !(&x[62:31])) s = S_OVF_LOW;
        return s;
    endfunction

    // register file, two copies for two reads per cycle
    svm_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf0 (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_wa), .i_wdata(rf_wd),
        .i_raddr(rf_ra0), .o_rdata(rf_rd0)
    );
    svm_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf1 (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_wa), .i_wdata(rf_wd),
        .i_raddr(rf_ra1), .o_rdata(rf_rd1)
    );

    // stack memory
    svm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd),
        .i_raddr(st_ra), .o_rdata(st_rd)
    );

    svm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(r_vb), .i_divisor(r_vc), .o_done(div_done), .o_quot(div_q)
    );

    // stack index for the current instruction
    always_comb begin
        case (r_uop.kind)
            K_PUSH:    idx = r_sc;
            K_POP:     idx = r_sc - 32'd1;
            K_LOAD:    idx = r_vb;
            K_STORE:   idx = r_va;
            K_LOADI:   idx = r_uop.imm;
            K_STOREI:  idx = r_uop.imm;
            K_LOADSC:  idx = r_sc - r_vb - 32'd1;
            K_STORESC: idx = r_sc - r_va - 32'd1;
            default:   idx = '0;
        endcase
        idx_ok = !idx[31] && (idx < 32'(STACK_DEPTH));
    end

    // execute and write-back decision
    always_comb begin
        add_x    = {r_vb[31], r_vb} + {r_vc[31], r_vc};
        sub_x    = {r_vb[31], r_vb} - {r_vc[31], r_vc};
        reg_req  = 1'b0;
        reg_val  = '0;
        ovf_st   = S_OK;
        stk_req  = 1'b0;
        stk_val  = '0;
        jump     = 1'b0;
        fatal    = 1'b0;
        fatal_st = S_OK;
        n_test   = r_test;
        n_pen    = r_pen;
        n_exit   = r_exit;
        case (r_uop.kind)
            K_EXIT: n_exit = 1'b1;
            K_MOVI: begin
                reg_req = 1'b1;
                reg_val = r_uop.imm;
            end
            K_ADD: begin
                reg_req = 1'b1;
                reg_val = add_x[31:0];
                ovf_st  = ovf33(add_x);
            end
            K_MOV: begin
                reg_req = 1'b1;
                reg_val = r_vb;
            end
            K_SUB: begin
                reg_req = 1'b1;
                reg_val = sub_x[31:0];
                ovf_st  = ovf33(sub_x);
            end
            K_MUL: begin
                reg_req = 1'b1;
                reg_val = r_prod[31:0];
                ovf_st  = ovf64(r_prod);
            end
            K_DIV: begin
                if (r_vc == '0) begin
                    fatal    = 1'b1;
                    fatal_st = S_DIV_ZERO;
                end else begin
                    reg_req = 1'b1;
                    reg_val = div_q[31:0];
                    ovf_st  = ovf33(div_q);
                end
            end
            K_INC: begin
                reg_req = 1'b1;
                reg_val = r_va + 32'd1;
                if (r_va == 32'h7fff_ffff) ovf_st = S_OVF_HIGH;
            end
            K_DEC: begin
                reg_req = 1'b1;
                reg_val = r_va - 32'd1;
                if (r_va == 32'h8000_0000) ovf_st = S_OVF_LOW;
            end
            K_JMP:   jump = 1'b1;
            K_JT:    jump = r_test;
            K_JNT:   jump = !r_test;
            K_CMPEQ: n_test = (r_va == r_vb);
            K_CMPLT: n_test = ($signed(r_va) < $signed(r_vb));
            K_PUSH, K_STOREI: begin
                stk_req = r_idx_ok;
                stk_val = r_va;
            end
            K_STORE, K_STORESC: begin
                stk_req = r_idx_ok;
                stk_val = r_vb;
            end
            K_POP, K_LOAD, K_LOADI, K_LOADSC: begin
                reg_req = r_idx_ok;
                reg_val = r_sd;
            end
            K_PENDOWN: n_pen = 1'b1;
            K_PENUP:   n_pen = 1'b0;
            default: ;
        endcase
        if ((r_uop.stk_rd || r_uop.stk_wr) && !r_idx_ok) begin
            fatal    = 1'b1;
            fatal_st = S_STACK_RANGE;
        end

        // register write checks
        ref_st = S_OK;
        commit = 1'b0;
        if (reg_req) begin
            if (r_uop.reg_a == REG_SC) ref_st = S_WR_SC;
            else if (r_uop.reg_a == REG_R0) ref_st = S_WR_R0;
            else if (r_uop.reg_a == REG_TC &&
                     (reg_val[31] || reg_val > 32'(TC_MAX))) ref_st = S_TC_RANGE;
            else if (r_uop.reg_a < 4'(NUM_REGS)) commit = 1'b1;
        end

        if (fatal) wb_st = fatal_st;
        else if (reg_req) wb_st = (ref_st != S_OK) ? ref_st : ovf_st;
        else wb_st = S_OK;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_CLEAR: if (r_clr == AW'(STACK_DEPTH - 1)) n_state = BK_IDLE;
            BK_IDLE:  if (i_uop_valid && !r_res_vld) n_state = BK_RD_BC;
            BK_RD_BC: n_state = BK_RD_A;
            BK_RD_A:  n_state = BK_CAP_A;
            BK_CAP_A: n_state = BK_EXEC;
            BK_EXEC:  n_state = (r_uop.kind == K_DIV && r_vc != '0) ? BK_DIV : BK_MEM;
            BK_MEM:   n_state = BK_WB;
            BK_DIV:   if (div_done) n_state = BK_WB;
            BK_WB:    n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_uop_pop  = (r_state == BK_IDLE) && i_uop_valid && !r_res_vld;
        o_clearing = (r_state == BK_CLEAR);
        div_start  = (r_state == BK_EXEC) && (r_uop.kind == K_DIV) && (r_vc != '0);
        rf_ra0     = (r_state == BK_RD_BC) ? r_uop.reg_b[RAW-1:0] : r_uop.reg_a[RAW-1:0];
        rf_ra1     = r_uop.reg_c[RAW-1:0];
        rf_we      = (r_state == BK_WB) && (commit || jump);
        rf_wa      = jump ? REG_PC[RAW-1:0] : r_uop.reg_a[RAW-1:0];
        rf_wd      = jump ? r_va : reg_val;
        st_ra      = idx[AW-1:0];
        st_we      = (r_state == BK_CLEAR) || ((r_state == BK_WB) && stk_req);
        st_wa      = (r_state == BK_CLEAR) ? r_clr : r_saddr;
        st_wd      = (r_state == BK_CLEAR) ? 32'd0 : stk_val;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_CLEAR;
            r_clr     <= '0;
            r_rf_vld  <= '0;
            r_sc      <= '0;
            r_test    <= 1'b0;
            r_pen     <= 1'b0;
            r_exit    <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_res_pop && r_res_vld) r_res_vld <= 1'b0;
            if (r_state == BK_WB) begin
                r_res_vld <= 1'b1;
                r_test    <= n_test;
                r_pen     <= n_pen;
                r_exit    <= n_exit;
                if (rf_we) r_rf_vld[rf_wa] <= 1'b1;
                if (r_uop.kind == K_PUSH && r_idx_ok) r_sc <= r_sc + 32'd1;
                if (r_uop.kind == K_POP && r_idx_ok)  r_sc <= r_sc - 32'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_uop_pop) r_uop <= i_uop;
        if (r_state == BK_RD_A) begin
            r_vb <= rf_map(r_uop.reg_b, r_rf_vld, rf_rd0, r_sc);
            r_vc <= rf_map(r_uop.reg_c, r_rf_vld, rf_rd1, r_sc);
        end
        if (r_state == BK_CAP_A) r_va <= rf_map(r_uop.reg_a, r_rf_vld, rf_rd0, r_sc);
        if (r_state == BK_EXEC) begin
            r_prod   <= 64'($signed(r_vb) * $signed(r_vc));
            r_idx_ok <= idx_ok;
            r_saddr  <= idx[AW-1:0];
        end
        if (r_state == BK_MEM) r_sd <= st_rd;
        if (r_state == BK_WB) begin
            r_res.status       <= wb_st;
            r_res.fatal        <= fatal;
            r_res.exit_req     <= n_exit;
            r_res.test_flag    <= n_test;
            r_res.pen_down     <= n_pen;
            r_res.jump_taken   <= jump;
            r_res.jump_target  <= jump ? r_va : 32'd0;
            r_res.dest_written <= commit || stk_req;
            r_res.dest_value   <= commit ? reg_val : (stk_req ? stk_val : 32'd0);
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_vld;

endmodule

>>> sv/small_vm_execute_unit_core.sv
// ----------------------------------------------------------------------------
// small_vm_execute_unit_core
// Executes decoded vm instructions, one result per instruction.
// ----------------------------------------------------------------------------
// An instruction passes from the queue head to its result through operand
// reads from the register file RAMs, execute, stack RAM read and write-back;
// a divide with a nonzero divisor waits on the one bit per cycle divider
// instead of the stack RAM read. Instructions run one at a time. After reset
// a clearing pass zeroes the stack RAM while full stays high.
module small_vm_execute_unit_core #(
    parameter int STACK_DEPTH = 256,
    parameter int TC_MAX      = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [4:0]         i_kind,
    input  logic [3:0]         i_reg_a,
    input  logic [3:0]         i_reg_b,
    input  logic [3:0]         i_reg_c,
    input  logic signed [31:0] i_imm,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         o_status,
    output logic               o_fatal,
    output logic               o_exit_req,
    output logic               o_test_flag,
    output logic               o_pen_down,
    output logic               o_jump_taken,
    output logic signed [31:0] o_jump_target,
    output logic               o_dest_written,
    output logic signed [31:0] o_dest_value
);
    import svm_pkg::*;

    t_uop    f_uop, q_uop;
    logic    f_push, q_full, q_valid, q_pop, clearing, res_vld;
    t_result res;

    svm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_kind(i_kind), .i_reg_a(i_reg_a), .i_reg_b(i_reg_b),
        .i_reg_c(i_reg_c), .i_imm(i_imm), .i_hold(clearing),
        .i_q_full(q_full), .o_q_push(f_push), .o_uop(f_uop)
    );

    svm_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_push), .i_data(f_uop),
        .o_full(q_full), .i_pop(q_pop), .o_data(q_uop), .o_valid(q_valid)
    );

    svm_back #(.STACK_DEPTH(STACK_DEPTH), .TC_MAX(TC_MAX)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_uop(q_uop), .i_uop_valid(q_valid),
        .o_uop_pop(q_pop), .o_clearing(clearing), .o_res(res),
        .o_res_valid(res_vld), .i_res_pop(pop)
    );

    // result unpacking
    assign empty          = !res_vld;
    assign o_status       = res.status;
    assign o_fatal        = res.fatal;
    assign o_exit_req     = res.exit_req;
    assign o_test_flag    = res.test_flag;
    assign o_pen_down     = res.pen_down;
    assign o_jump_taken   = res.jump_taken;
    assign o_jump_target  = res.jump_target;
    assign o_dest_written = res.dest_written;
    assign o_dest_value   = res.dest_value;

    // fatal flag agrees with status
    a_fatal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_fatal == (o_status == 3'(S_DIV_ZERO) ||
                                o_status == 3'(S_STACK_RANGE))))
        else $error("fatal flag disagrees with status");

    // a fatal instruction writes nothing
    a_fatal_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_fatal) |-> !o_dest_written)
        else $error("fatal instruction wrote a destination");

    // idle value fields are zero
    a_dest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_dest_written) |-> (o_dest_value == 32'sd0))
        else $error("dest value without write");

    a_jump_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_jump_taken) |-> (o_jump_target == 32'sd0))
        else $error("jump target without jump");

endmodule

>>> sim/tb_small_vm_execute_unit_core.sv
// ----------------------------------------------------------------------------
// tb_small_vm_execute_unit_core
// Self-checking bench for the vm execute unit: drives decoded instructions
// through the input queue, predicts each result from its own copy of the
// register file, stack and flags, and checks every transfer on the result side.
// ----------------------------------------------------------------------------
module tb_small_vm_execute_unit_core;
    import svm_pkg::*;

    localparam int STK_DEPTH   = 256;
    localparam int TC_LIMIT    = 7;
    localparam int STALL_LIMIT = 5000;

    // instruction set model with the queue of results still due
    class vm_scoreboard;
        logic [31:0] regs [NUM_REGS];
        logic [31:0] stk [STK_DEPTH];
        logic        test_b, pen_b, exit_b;
        logic        wr_flag;
        logic [31:0] wr_val;
        t_result     due_q [$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (stk[i]) stk[i] = '0;
            test_b = 0; pen_b = 0; exit_b = 0; errors = 0;
        endfunction

        function logic [31:0] rd(logic [3:0] r);
            return (r < NUM_REGS) ? regs[r] : 32'd0;
        endfunction

        function longint sx(logic [31:0] v);
            return longint'($signed(v));
        endfunction

        function t_status write_reg(logic [3:0] r, logic [31:0] v);
            if (r == REG_SC) return S_WR_SC;
            if (r == REG_R0) return S_WR_R0;
            if (r == REG_TC && (sx(v) < 0 || sx(v) > TC_LIMIT)) return S_TC_RANGE;
            if (r >= NUM_REGS) return S_OK;
            regs[r] = v;
            wr_flag = 1;
            wr_val = v;
            return S_OK;
        endfunction

        function t_status range_status(longint exact);
            if (exact > 64'sd2147483647) return S_OVF_HIGH;
            if (exact < -64'sd2147483648) return S_OVF_LOW;
            return S_OK;
        endfunction

        function t_status arith(logic [3:0] a, longint exact);
            t_status s;
            s = write_reg(a, exact[31:0]);
            return (s == S_OK) ? range_status(exact) : s;
        endfunction

        function bit in_stack(longint idx);
            return idx >= 0 && idx < STK_DEPTH;
        endfunction

        function t_status store_at(longint idx, logic [31:0] v);
            if (!in_stack(idx)) return S_STACK_RANGE;
            stk[idx] = v;
            wr_flag = 1;
            wr_val = v;
            return S_OK;
        endfunction

        function t_status load_to(logic [3:0] a, longint idx);
            if (!in_stack(idx)) return S_STACK_RANGE;
            return write_reg(a, stk[idx]);
        endfunction

        // execute one accepted instruction and queue its result
        function void note_instr(logic [4:0] k, logic [3:0] a, logic [3:0] b,
                                 logic [3:0] c, logic [31:0] imm);
            t_result r;
            t_status s;
            longint  va, vb, vc, sc_v;
            logic    jump;
            va = sx(rd(a)); vb = sx(rd(b)); vc = sx(rd(c));
            sc_v = sx(regs[REG_SC]);
            s = S_OK; jump = 0; wr_flag = 0; wr_val = '0;
            r = '0;
            case (t_kind'(k))
                K_EXIT:    exit_b = 1;
                K_MOVI:    s = write_reg(a, imm);
                K_ADD:     s = arith(a, vb + vc);
                K_MOV:     s = write_reg(a, rd(b));
                K_SUB:     s = arith(a, vb - vc);
                K_MUL:     s = arith(a, vb * vc);
                K_DIV:     s = (vc == 0) ? S_DIV_ZERO : arith(a, vb / vc);
                K_INC: begin
                    s = write_reg(a, rd(a) + 32'd1);
                    if (s == S_OK && va == 64'sd2147483647) s = S_OVF_HIGH;
                end
                K_DEC: begin
                    s = write_reg(a, rd(a) - 32'd1);
                    if (s == S_OK && va == -64'sd2147483648) s = S_OVF_LOW;
                end
                K_JMP:     jump = 1;
                K_CMPEQ:   test_b = (va == vb);
                K_CMPLT:   test_b = (va < vb);
                K_JT:      jump = test_b;
                K_JNT:     jump = !test_b;
                K_PUSH: begin
                    s = store_at(sc_v, rd(a));
                    if (s == S_OK) regs[REG_SC] = regs[REG_SC] + 32'd1;
                end
                K_POP: begin
                    if (!in_stack(sc_v - 1)) s = S_STACK_RANGE;
                    else begin
                        regs[REG_SC] = regs[REG_SC] - 32'd1;
                        s = write_reg(a, stk[sc_v - 1]);
                    end
                end
                K_LOAD:    s = load_to(a, vb);
                K_STORE:   s = store_at(va, rd(b));
                K_LOADI:   s = load_to(a, sx(imm));
                K_STOREI:  s = store_at(sx(imm), rd(a));
                K_LOADSC:  s = load_to(a, sx(regs[REG_SC] - rd(b) - 32'd1));
                K_STORESC: s = store_at(sx(regs[REG_SC] - rd(a) - 32'd1), rd(b));
                K_PENDOWN: pen_b = 1;
                K_PENUP:   pen_b = 0;
                default: ;
            endcase
            if (jump) begin
                r.jump_target = rd(a);
                regs[REG_PC] = r.jump_target;
            end
            r.status       = s;
            r.fatal        = (s == S_DIV_ZERO || s == S_STACK_RANGE);
            r.exit_req     = exit_b;
            r.test_flag    = test_b;
            r.pen_down     = pen_b;
            r.jump_taken   = jump;
            r.dest_written = wr_flag;
            r.dest_value   = wr_flag ? wr_val : 32'd0;
            due_q.push_back(r);
        endfunction

        // compare one result transfer with the oldest due result
        function void check_result(t_result got);
            t_result e;
            if (due_q.size() == 0) begin
                $error("result with nothing due: status %0d", got.status);
                errors++;
                return;
            end
            e = due_q.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status); errors++;
            end
            if (got.fatal !== e.fatal) begin
                $error("fatal: expected %0d, got %0d", e.fatal, got.fatal); errors++;
            end
            if (got.exit_req !== e.exit_req) begin
                $error("exit_req: expected %0d, got %0d", e.exit_req, got.exit_req);
                errors++;
            end
            if (got.test_flag !== e.test_flag) begin
                $error("test_flag: expected %0d, got %0d", e.test_flag, got.test_flag);
                errors++;
            end
            if (got.pen_down !== e.pen_down) begin
                $error("pen_down: expected %0d, got %0d", e.pen_down, got.pen_down);
                errors++;
            end
            if (got.jump_taken !== e.jump_taken) begin
                $error("jump_taken: expected %0d, got %0d", e.jump_taken, got.jump_taken);
                errors++;
            end
            if (got.jump_target !== e.jump_target) begin
                $error("jump_target: expected %h, got %h", e.jump_target, got.jump_target);
                errors++;
            end
            if (got.dest_written !== e.dest_written) begin
                $error("dest_written: expected %0d, got %0d",
                       e.dest_written, got.dest_written);
                errors++;
            end
            if (got.dest_value !== e.dest_value) begin
                $error("dest_value: expected %h, got %h", e.dest_value, got.dest_value);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               push = 0;
    logic               full;
    logic [4:0]         i_kind = '0;
    logic [3:0]         i_reg_a = '0, i_reg_b = '0, i_reg_c = '0;
    logic signed [31:0] i_imm = '0;
    logic               empty;
    logic               pop = 0;
    logic [2:0]         o_status;
    logic               o_fatal, o_exit_req, o_test_flag, o_pen_down;
    logic               o_jump_taken, o_dest_written;
    logic signed [31:0] o_jump_target, o_dest_value;

    vm_scoreboard sb = new();
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           quiet_cycles = 0;

    small_vm_execute_unit_core #(.STACK_DEPTH(STK_DEPTH), .TC_MAX(TC_LIMIT)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_kind(i_kind), .i_reg_a(i_reg_a), .i_reg_b(i_reg_b), .i_reg_c(i_reg_c),
        .i_imm(i_imm), .empty(empty), .pop(pop), .o_status(o_status),
        .o_fatal(o_fatal), .o_exit_req(o_exit_req), .o_test_flag(o_test_flag),
        .o_pen_down(o_pen_down), .o_jump_taken(o_jump_taken),
        .o_jump_target(o_jump_target), .o_dest_written(o_dest_written),
        .o_dest_value(o_dest_value)
    );

    always #5 i_clk = ~i_clk;

    // receiver side stalls
    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= stall_pct);
    end

    // result transfers and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result('{t_status'(o_status), o_fatal, o_exit_req, o_test_flag,
                              o_pen_down, o_jump_taken, o_jump_target,
                              o_dest_written, o_dest_value});
        end
        if ((pop && !empty) || (push && !full)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // one instruction transfer, with random sender gaps
    task automatic send(t_kind k, logic [3:0] a, logic [3:0] b, logic [3:0] c,
                        logic [31:0] imm);
        while ($urandom_range(99) < idle_pct) begin
            push <= 0;
            @(negedge i_clk);
        end
        push <= 1;
        i_kind <= k; i_reg_a <= a; i_reg_b <= b; i_reg_c <= c; i_imm <= imm;
        do @(posedge i_clk); while (full);
        sb.note_instr(k, a, b, c, imm);
        @(negedge i_clk);
    endtask

    task automatic drain();
        push <= 0;
        while (sb.due_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [3:0] pick_reg();
        return ($urandom_range(99) < 75) ? 4'($urandom_range(1, 7))
                                         : 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [31:0] pick_imm();
        int m;
        m = $urandom_range(99);
        if (m < 55) return 32'($urandom_range(0, 12)) - 32'd2;
        if (m < 70) return 32'($urandom_range(0, 300));
        if (m < 80) return ($urandom_range(1)) ? 32'h7fffffff - 32'($urandom_range(2))
                                               : 32'h80000000 + 32'($urandom_range(2));
        return $urandom;
    endfunction

    // random instruction stream, mostly valid kinds on small registers
    task automatic random_phase(int n);
        t_kind k;
        repeat (n) begin
            k = ($urandom_range(99) < 4) ? t_kind'($urandom_range(0, 31))
                                         : t_kind'($urandom_range(0, 23));
            if ($urandom_range(99) < 20) k = ($urandom_range(1)) ? K_MOVI : K_PUSH;
            send(k, pick_reg(), pick_reg(), pick_reg(), pick_imm());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: refused writes, overflow, fatal cases, stack edges, flags
        send(K_POP,     4'd1, 4'd0, 4'd0, 32'd0);
        send(K_MOVI,    REG_SC, 4'd0, 4'd0, 32'd5);
        send(K_MOVI,    REG_R0, 4'd0, 4'd0, 32'd5);
        send(K_MOVI,    REG_TC, 4'd0, 4'd0, 32'd8);
        send(K_MOVI,    REG_TC, 4'd0, 4'd0, 32'hffffffff);
        send(K_MOVI,    REG_TC, 4'd0, 4'd0, 32'd7);
        send(K_MOVI,    4'd1, 4'd0, 4'd0, 32'h7fffffff);
        send(K_MOVI,    4'd2, 4'd0, 4'd0, 32'h80000000);
        send(K_MOVI,    4'd3, 4'd0, 4'd0, 32'hffffffff);
        send(K_ADD,     4'd4, 4'd1, 4'd1, 32'd0);
        send(K_SUB,     4'd4, 4'd2, 4'd1, 32'd0);
        send(K_MUL,     4'd4, 4'd1, 4'd2, 32'd0);
        send(K_DIV,     4'd4, 4'd2, 4'd3, 32'd0);
        send(K_DIV,     4'd4, 4'd1, 4'd0, 32'd0);
        send(K_INC,     4'd1, 4'd0, 4'd0, 32'd0);
        send(K_DEC,     4'd2, 4'd0, 4'd0, 32'd0);
        send(K_MOV,     4'd15, 4'd3, 4'd0, 32'd0);
        send(K_PUSH,    4'd3, 4'd0, 4'd0, 32'd0);
        send(K_STOREI,  4'd1, 4'd0, 4'd0, 32'd255);
        send(K_LOADI,   4'd5, 4'd0, 4'd0, 32'd256);
        send(K_LOADI,   4'd5, 4'd0, 4'd0, 32'hffffffff);
        send(K_LOADSC,  4'd5, 4'd0, 4'd0, 32'd0);
        send(K_STORESC, 4'd0, 4'd1, 4'd0, 32'd0);
        send(K_STORE,   4'd0, 4'd1, 4'd0, 32'd0);
        send(K_LOAD,    4'd6, 4'd0, 4'd0, 32'd0);
        send(K_POP,     REG_SC, 4'd0, 4'd0, 32'd0);
        send(K_CMPLT,   4'd2, 4'd1, 4'd0, 32'd0);
        send(K_JT,      4'd1, 4'd0, 4'd0, 32'd0);
        send(K_CMPEQ,   4'd1, 4'd2, 4'd0, 32'd0);
        send(K_JNT,     4'd3, 4'd0, 4'd0, 32'd0);
        send(K_JMP,     REG_PC, 4'd0, 4'd0, 32'd0);
        send(K_PENDOWN, 4'd0, 4'd0, 4'd0, 32'd0);
        send(K_PENUP,   4'd0, 4'd0, 4'd0, 32'd0);
        send(K_EXIT,    4'd0, 4'd0, 4'd0, 32'd0);
        send(t_kind'(5'd31), 4'd15, 4'd15, 4'd15, 32'd0);

        // sender holds off until every result has come back
        drain();

        random_phase(255);
        idle_pct = 60;
        random_phase(255);
        idle_pct = 0; stall_pct = 60;
        random_phase(255);
        idle_pct = 9; stall_pct = 9;
        random_phase(255);

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
